// File: rtl/bil_pkg.sv
// Package with shared types, constants and helpers for the bin index lookup.
`timescale 1ns / 1ps
`default_nettype none
package bil_pkg;
	localparam int MAX_EDGES   = 32;
	localparam int COORD_WIDTH = 32;
	localparam int AXES        = 7;
	localparam int SLOT_W      = $clog2(MAX_EDGES);
	localparam int COUNT_W     = 6;
	localparam int INDEX_W     = 25;
	localparam int STEPS       = 5;
	localparam int STEP_W      = 3;

	typedef enum logic [2:0] {
		AX_X = 3'd0, AX_Y = 3'd1, AX_Z = 3'd2, AX_BETA = 3'd3,
		AX_THETA = 3'd4, AX_PHI = 3'd5, AX_R = 3'd6, AX_NONE = 3'd7
	} axis_t;

	typedef enum logic [1:0] {
		MODE_LOAD = 2'd0, MODE_SCINT = 2'd1, MODE_FIBER = 2'd2, MODE_UNUSED = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_CMP, ST_ACC, ST_DONE
	} state_t;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	// Neighbor signals handed from one cell to the next.
	typedef struct packed {
		logic le;    // this edge is at or below the key
		logic seen;  // a bin was already found at a lower position
	} link_t;

	// Axis visited at a given step of a lookup.
	function automatic axis_t step_axis(input mode_t m, input logic [STEP_W-1:0] s);
		axis_t a;
		a = AX_NONE;
		if (m == MODE_SCINT) begin
			case (s)
				3'd0:    a = AX_X;
				3'd1:    a = AX_Y;
				default: a = AX_Z;
			endcase
		end else begin
			case (s)
				3'd0:    a = AX_BETA;
				3'd1:    a = AX_THETA;
				3'd2:    a = AX_PHI;
				3'd3:    a = AX_R;
				default: a = AX_Z;
			endcase
		end
		return a;
	endfunction

	// Number of bins of an axis given its edge count.
	function automatic logic [COUNT_W-1:0] bins_of(input logic [COUNT_W-1:0] n);
		logic [COUNT_W-1:0] u;
		u = (n > COUNT_W'(MAX_EDGES)) ? COUNT_W'(MAX_EDGES) : n;
		return (u >= COUNT_W'(2)) ? u - COUNT_W'(1) : '0;
	endfunction
endpackage
`default_nettype wire

// File: rtl/bil_cell.sv
// One edge position: holds that edge of every axis and compares it to the key.
`timescale 1ns / 1ps
`default_nettype none
module bil_cell import bil_pkg::*; (
	input  wire logic   clk,
	input  wire logic   wr_en,
	input  wire axis_t  wr_axis,
	input  wire coord_t wr_value,
	input  wire axis_t  rd_axis,
	input  wire coord_t key,
	input  wire logic   active,
	input  wire link_t  link_in,
	output link_t       link_out,
	output logic        first
);
	coord_t edge_q [AXES];
	coord_t e;
	logic   ge;
	logic   hit;

	// Edge storage, one word per axis.
	always_ff @(posedge clk) begin
		if (wr_en && wr_axis != AX_NONE) begin
			edge_q[wr_axis] <= wr_value;
		end
	end

	// Compare against the key; a hit needs the lower neighbor at or below it.
	always_comb begin
		e             = (rd_axis == AX_NONE) ? '0 : edge_q[rd_axis];
		ge            = (e >= key);
		hit           = active & ge & link_in.le;
		first         = hit & ~link_in.seen;
		link_out.le   = (e <= key);
		link_out.seen = link_in.seen | hit;
	end
endmodule
`default_nettype wire

// File: rtl/multi_axis_bin_index_lookup.sv
// Top level of the multi-axis bin index lookup.
// Load requests (mode 0) write one edge into one of seven axis tables and produce no result.
// A scintillator lookup walks x, y, z and a fiber lookup walks beta, theta, phi, r, z; for each
// axis a compare across the row of MAX_EDGES edge cells (ST_CMP) is followed by a multiply-add
// into the flat index (ST_ACC), and ST_DONE then hands off the result. Input requests are
// taken only while no lookup is in progress. The user must set edge counts over the cfg
// write port only while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module multi_axis_bin_index_lookup import bil_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_wr_en,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [5:0]   cfg_data,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// mode, axis_select, edge_slot, edge_value, pos_x, pos_y, pos_z, speed_beta,
	// angle_theta, angle_phi, fiber_radius, zero fill
	input  wire logic [271:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// bin_index, zero fill
	output logic [31:0]       m_axis_tdata,
	// found
	output logic              m_axis_tuser
);
	logic [COUNT_W-1:0] count_q [AXES];
	state_t             state_q, state_d;
	mode_t              mode_q;
	coord_t             coord_q [STEPS];
	logic [STEP_W-1:0]  step_q;
	logic [SLOT_W-1:0]  bin_s1;
	logic               hit_s1;
	logic [INDEX_W-1:0] idx_q;
	logic               miss_q;
	logic               out_valid_q;
	logic               out_found_q;
	logic [INDEX_W-1:0] out_index_q;

	mode_t              in_mode;
	axis_t              in_axis;
	logic [SLOT_W-1:0]  in_slot;
	coord_t             in_edge;
	logic               accept;
	logic               load_en;
	axis_t              cur_axis;
	coord_t             cur_key;
	logic [COUNT_W-1:0] cur_count;
	logic               last_step;
	link_t              link [MAX_EDGES+1];
	logic [MAX_EDGES-1:0] first_v;
	logic [SLOT_W-1:0]  bin_c;
	logic [INDEX_W+COUNT_W-1:0] prod;

	assign in_mode = mode_t'(s_axis_tdata[1:0]);
	assign in_axis = axis_t'(s_axis_tdata[4:2]);
	assign in_slot = s_axis_tdata[9:5];
	assign in_edge = s_axis_tdata[41:10];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept  = s_axis_tvalid & s_axis_tready;
	assign load_en = accept && in_mode == MODE_LOAD;

	// Edge count registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) count_q[i] <= '0;
		end else if (cfg_wr_en && cfg_index != 3'(AXES)) begin
			count_q[cfg_index] <= cfg_data;
		end
	end

	assign cur_axis  = step_axis(mode_q, step_q);
	assign cur_key   = coord_q[step_q];
	assign cur_count = count_q[cur_axis];
	assign last_step = (mode_q == MODE_SCINT) ? (step_q == STEP_W'(2)) : (step_q == STEP_W'(4));

	// Row of edge cells.
	assign link[0] = '{le: 1'b0, seen: 1'b0};
	for (genvar g = 0; g < MAX_EDGES; g++) begin : g_cell
		bil_cell u_cell (
			.clk      (clk),
			.wr_en    (load_en && in_slot == SLOT_W'(g)),
			.wr_axis  (in_axis),
			.wr_value (in_edge),
			.rd_axis  (cur_axis),
			.key      (cur_key),
			.active   ({1'b0, cur_count} > (COUNT_W+1)'(g)),
			.link_in  (link[g]),
			.link_out (link[g+1]),
			.first    (first_v[g])
		);
	end

	// Bin number is one below the position of the first hit.
	always_comb begin
		bin_c = '0;
		for (int i = 1; i < MAX_EDGES; i++) begin
			if (first_v[i]) bin_c = bin_c | SLOT_W'(i - 1);
		end
	end

	assign prod = idx_q * bins_of(cur_count);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept && (in_mode == MODE_SCINT || in_mode == MODE_FIBER))
				state_d = ST_CMP;
			ST_CMP:  state_d = ST_ACC;
			ST_ACC:  state_d = last_step ? ST_DONE : ST_CMP;
			ST_DONE: if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Lookup datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			mode_q <= MODE_LOAD;
			miss_q <= 1'b0;
		end else begin
			if (state_q == ST_IDLE && accept) begin
				mode_q <= in_mode;
				step_q <= '0;
				miss_q <= 1'b0;
			end else if (state_q == ST_ACC) begin
				miss_q <= miss_q | ~hit_s1;
				if (!last_step) step_q <= step_q + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			idx_q <= '0;
			if (in_mode == MODE_SCINT) begin
				coord_q[0] <= s_axis_tdata[73:42];
				coord_q[1] <= s_axis_tdata[105:74];
				coord_q[2] <= s_axis_tdata[137:106];
				coord_q[3] <= s_axis_tdata[137:106];
				coord_q[4] <= s_axis_tdata[137:106];
			end else begin
				coord_q[0] <= s_axis_tdata[169:138];
				coord_q[1] <= s_axis_tdata[201:170];
				coord_q[2] <= s_axis_tdata[233:202];
				coord_q[3] <= s_axis_tdata[265:234];
				coord_q[4] <= s_axis_tdata[137:106];
			end
		end
		if (state_q == ST_CMP) begin
			bin_s1 <= bin_c;
			hit_s1 <= link[MAX_EDGES].seen;
		end
		if (state_q == ST_ACC) begin
			idx_q <= prod[INDEX_W-1:0] + INDEX_W'(bin_s1);
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!out_valid_q || m_axis_tready)) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || m_axis_tready)) begin
			out_found_q <= ~miss_q;
			out_index_q <= miss_q ? '0 : idx_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_index_q};
	assign m_axis_tuser  = out_found_q;

	// A not-found result always carries a zero index.
	a_zero_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 32'd0)
		else $error("not-found result with nonzero index");

	// The step counter never passes step 4, the last axis of a fiber lookup.
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> step_q <= STEP_W'(4))
		else $error("step counter out of range");

	// A finished lookup always leads to a pending result.
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && state_d == ST_IDLE |=> m_axis_tvalid)
		else $error("finished lookup produced no result");
endmodule
`default_nettype wire

// File: sim/bin_lookup_checker.sv
// Checker that predicts and compares the results of the bin index lookup.
`timescale 1ns / 1ps
module bin_lookup_checker import bil_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_wr_en,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [5:0]   cfg_data,
	input  wire logic         s_axis_tvalid,
	input  wire logic         s_axis_tready,
	input  wire logic [271:0] s_axis_tdata,
	input  wire logic         m_axis_tvalid,
	input  wire logic         m_axis_tready,
	input  wire logic [31:0]  m_axis_tdata,
	input  wire logic         m_axis_tuser,
	output int                fail_count,
	output int                lookups_pending
);
	typedef struct {
		logic                found;
		logic [INDEX_W-1:0]  index;
	} bin_result_t;

	coord_t             edge_tab [AXES][MAX_EDGES];
	logic [COUNT_W-1:0] edge_cnt [AXES];
	bin_result_t        bins_due [$];

	// Count of edges actually used on one axis.
	function automatic int unsigned used_edges(axis_t a);
		return (edge_cnt[a] > MAX_EDGES) ? MAX_EDGES : edge_cnt[a];
	endfunction

	function automatic longint unsigned bin_span(axis_t a);
		int unsigned n;
		n = used_edges(a);
		return (n >= 2) ? n - 1 : 0;
	endfunction

	// First bin whose lower and upper edges enclose the value; a miss flags not found.
	function automatic longint unsigned find_bin(axis_t a, coord_t v, inout bit miss);
		int unsigned n;
		n = used_edges(a);
		for (int unsigned i = 1; i < n; i++) begin
			if (edge_tab[a][i] >= v && edge_tab[a][i-1] <= v)
				return i - 1;
		end
		miss = 1'b1;
		return 0;
	endfunction

	task automatic report(input string what);
		$display("%0t ns: lookup result error: %s", $time, what);
		fail_count++;
	endtask

	assign lookups_pending = bins_due.size();

	// Track the edge counts as they are written.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < AXES; a++) edge_cnt[a] = '0;
		end else if (cfg_wr_en && cfg_index < AXES) begin
			edge_cnt[cfg_index] = cfg_data;
		end
	end

	// Predict each accepted request.
	always @(posedge clk) begin
		mode_t           md;
		axis_t           ax;
		bit              miss;
		longint unsigned acc;
		bin_result_t     r;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			md   = mode_t'(s_axis_tdata[1:0]);
			ax   = axis_t'(s_axis_tdata[4:2]);
			miss = 1'b0;
			acc  = 0;
			case (md)
				MODE_LOAD: begin
					if (ax != AX_NONE)
						edge_tab[ax][s_axis_tdata[9:5]] = s_axis_tdata[41:10];
				end
				MODE_SCINT: begin
					acc = find_bin(AX_X, s_axis_tdata[73:42], miss);
					acc = acc * bin_span(AX_Y) + find_bin(AX_Y, s_axis_tdata[105:74], miss);
					acc = acc * bin_span(AX_Z) + find_bin(AX_Z, s_axis_tdata[137:106], miss);
				end
				MODE_FIBER: begin
					acc = find_bin(AX_BETA, s_axis_tdata[169:138], miss);
					acc = acc * bin_span(AX_THETA)
						+ find_bin(AX_THETA, s_axis_tdata[201:170], miss);
					acc = acc * bin_span(AX_PHI) + find_bin(AX_PHI, s_axis_tdata[233:202], miss);
					acc = acc * bin_span(AX_R) + find_bin(AX_R, s_axis_tdata[265:234], miss);
					acc = acc * bin_span(AX_Z) + find_bin(AX_Z, s_axis_tdata[137:106], miss);
				end
				default: ;
			endcase
			if (md == MODE_SCINT || md == MODE_FIBER) begin
				r.found = !miss;
				r.index = miss ? '0 : acc[INDEX_W-1:0];
				bins_due.insert(bins_due.size(), r);
			end
		end
	end

	// Compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		bin_result_t r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (bins_due.size() == 0) begin
				report("result with no lookup outstanding");
			end else begin
				r = bins_due.pop_front();
				if (m_axis_tuser !== r.found)
					report($sformatf("found %b, predicted %b", m_axis_tuser, r.found));
				if (m_axis_tdata !== {{(32-INDEX_W){1'b0}}, r.index})
					report($sformatf("bin index %0d, predicted %0d", m_axis_tdata, r.index));
			end
		end
	end
endmodule

// File: sim/tb_multi_axis_bin_index_lookup.sv
// Testbench top that drives requests into the bin index lookup and gives the verdict.
`timescale 1ns / 1ps
module tb_multi_axis_bin_index_lookup;
	import bil_pkg::*;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_wr_en = 1'b0;
	logic [2:0]   cfg_index = '0;
	logic [5:0]   cfg_data = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [271:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [31:0]  m_axis_tdata;
	logic         m_axis_tuser;
	int           fail_count;
	int           lookups_pending;
	int           sent = 0;
	int           quiet_cycles = 0;

	// Edge values loaded so far, used to aim lookups at real bins.
	coord_t edge_copy [AXES][MAX_EDGES];
	int     cnt_copy [AXES];

	always #5 clk = ~clk;

	multi_axis_bin_index_lookup uut (.*);

	bin_lookup_checker checker_i (.*);

	function automatic bit gaps_on();
		return !(sent >= 600 && sent < 760);
	endfunction

	// Send one request, with random gaps before it outside the no-gap stretch.
	task automatic send(input mode_t md, input axis_t ax, input logic [4:0] slot,
			input coord_t ev, input coord_t c [7]);
		logic [271:0] d;
		d = '0;
		d[1:0] = md;
		d[4:2] = ax;
		d[9:5] = slot;
		d[41:10] = ev;
		for (int k = 0; k < 7; k++) d[42 + 32*k +: 32] = c[k];
		if (gaps_on()) begin
			while ($urandom_range(99) < 29) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		forever begin
			@(posedge clk);
			if (s_axis_tready) break;
		end
		if (md == MODE_LOAD && ax != AX_NONE) edge_copy[ax][slot] = ev;
		sent++;
	endtask

	task automatic load_edge(input axis_t ax, input int slot, input coord_t ev);
		coord_t c [7];
		foreach (c[k]) c[k] = $urandom;
		send(MODE_LOAD, ax, slot[4:0], ev, c);
	endtask

	// Wait until every result is back, then let the block settle.
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (lookups_pending != 0) @(posedge clk);
		repeat (14) @(posedge clk);
	endtask

	// Write the edge count of every axis, plus a write to the unused index.
	task automatic set_counts(input int v [AXES]);
		for (int a = 0; a <= AXES; a++) begin
			@(negedge clk);
			cfg_wr_en <= 1'b1;
			cfg_index <= a[2:0];
			cfg_data  <= (a < AXES) ? v[a][5:0] : 6'(~v[0]);
			if (a < AXES) cnt_copy[a] = v[a];
			@(posedge clk);
		end
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Load one table with a sorted run of edges.
	task automatic fill_sorted(input axis_t ax, input bit full_span);
		longint v;
		longint stride;
		v = full_span ? -64'sd2147483648 : $signed(32'($urandom)) / 2;
		stride = full_span ? 64'd138547332 : $urandom_range(1 << 22, 1);
		for (int s = 0; s < MAX_EDGES; s++) begin
			if (full_span && s == MAX_EDGES - 1) v = 64'sd2147483647;
			if (v > 64'sd2147483647) v = 64'sd2147483647;
			load_edge(ax, s, coord_t'(v));
			v += ($urandom_range(3) == 0) ? 0 : stride;
		end
	endtask

	// Pick a coordinate, mostly inside the active bins of an axis.
	function automatic coord_t aim(input axis_t ax);
		int     n;
		int     j;
		longint lo;
		longint hi;
		n = (cnt_copy[ax] > MAX_EDGES) ? MAX_EDGES : cnt_copy[ax];
		if (n < 2 || $urandom_range(99) < 25) return $urandom;
		j  = $urandom_range(n - 2);
		lo = edge_copy[ax][j];
		hi = edge_copy[ax][j+1];
		case ($urandom_range(3))
			0: return coord_t'(lo);
			1: return coord_t'(hi);
			default: return (hi <= lo) ? coord_t'(lo)
				: coord_t'(lo + longint'({$urandom, $urandom} % (hi - lo + 1)));
		endcase
	endfunction

	task automatic lookup(input mode_t md);
		coord_t c [7];
		c[0] = aim(AX_X);
		c[1] = aim(AX_Y);
		c[2] = aim(AX_Z);
		c[3] = aim(AX_BETA);
		c[4] = aim(AX_THETA);
		c[5] = aim(AX_PHI);
		c[6] = aim(AX_R);
		send(md, axis_t'($urandom_range(7)), 5'($urandom), $urandom, c);
	endtask

	// Receiver: random stalls, one long hold-off, and a stretch with none.
	initial begin
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && sent >= 420) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (300) @(negedge clk);
			end
			m_axis_tready <= (!gaps_on()) || ($urandom_range(99) >= 29);
		end
	end

	// Watchdog on cycles with no traffic at all.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 3000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Stimulus and verdict.
	initial begin
		int     cnt [AXES];
		int     r;
		coord_t c [7];
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (cnt[a]) cnt[a] = MAX_EDGES;
		set_counts(cnt);
		for (int a = 0; a < AXES; a++) fill_sorted(axis_t'(a), a == AX_X || a == AX_BETA);

		// Directed: field extremes, exact edges, unused mode, bad axis.
		foreach (c[k]) c[k] = 32'sh80000000;
		send(MODE_SCINT, AX_X, 5'd0, '0, c);
		send(MODE_FIBER, AX_X, 5'd0, '0, c);
		foreach (c[k]) c[k] = 32'sh7fffffff;
		send(MODE_SCINT, AX_R, 5'd31, '1, c);
		send(MODE_FIBER, AX_R, 5'd31, '1, c);
		foreach (c[k]) c[k] = edge_copy[k][k];
		send(MODE_SCINT, AX_X, 5'd0, '0, c);
		send(MODE_FIBER, AX_X, 5'd0, '0, c);
		send(MODE_UNUSED, AX_X, 5'd0, '0, c);
		send(MODE_LOAD, AX_NONE, 5'd3, 32'sh12345678, c);
		for (int k = 0; k < 8; k++) lookup(($urandom_range(1)) ? MODE_SCINT : MODE_FIBER);

		// Phases over several count settings, extremes first.
		for (int ph = 0; ph < 12; ph++) begin
			drain();
			foreach (cnt[a]) begin
				case (ph)
					0: cnt[a] = MAX_EDGES;
					1: cnt[a] = 2;
					2: cnt[a] = (a == AX_Z) ? 1 : 8;
					3: cnt[a] = (a == AX_Y || a == AX_PHI) ? 0 : 5;
					4: cnt[a] = (a % 2) ? 63 : 33;
					default: cnt[a] = $urandom_range(MAX_EDGES, 2);
				endcase
			end
			set_counts(cnt);
			if (ph >= 5) fill_sorted(axis_t'($urandom_range(AXES - 1)), 1'b0);
			for (int k = 0; k < 62; k++) begin
				r = $urandom_range(99);
				if (r < 6)
					load_edge(axis_t'($urandom_range(AXES - 1)), $urandom_range(31), $urandom);
				else if (r < 9) begin
					foreach (c[j]) c[j] = $urandom;
					send((r == 6) ? MODE_UNUSED : MODE_LOAD, AX_NONE, 5'($urandom),
						$urandom, c);
				end else
					lookup((r < 54) ? MODE_SCINT : MODE_FIBER);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
